/* src/lsi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lsi_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int STEP_W   = 24;
    localparam int WGT_W    = 40;

    // Product and accumulator widths
    localparam int DPROD_W  = COEF_W + SAMPLE_W;       // plant product, Q.15
    localparam int YPROD_W  = WGT_W + SAMPLE_W;        // adaptive product, Q.32
    localparam int ACC_W    = 60;                      // error sum, Q.32, up to 7 taps
    localparam int EQ_W     = 32;                      // error in Q16.16
    localparam int P_W      = 32;                      // scaled error for the update
    localparam int PPROD_W  = STEP_W + 1 + EQ_W;       // step size times error
    localparam int UPD_W    = P_W + SAMPLE_W;          // update product

    localparam int PLANT_SHIFT = 17;                   // Q.15 to Q.32
    localparam int EQ_SHIFT    = 16;
    localparam int STEP_SHIFT  = 24;
    localparam int UPD_SHIFT   = 16;
    localparam int OUT_SHIFT   = 32;

    // Configuration map
    localparam int NUM_COEF   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = STEP_W;
    localparam int COEF_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 3'd4;

    localparam logic signed [COEF_W-1:0] COEF_RESET = 16'sd8192;
    localparam logic [STEP_W-1:0]        STEP_RESET = 24'd72058;

    // Strobes broadcast along the row of cells
    typedef struct packed {
        logic shift;    // load new sample, pass old one to the neighbor
        logic mul;      // register plant and adaptive products
        logic term;     // register the per-tap error term
        logic acc;      // ripple the error sum one cell further
        logic umul;     // register the update product
        logic upd;      // write the new weight
    } cell_ctrl_t;

    // Strobes for the error unit
    typedef struct packed {
        logic load_err;   // register output error and Q16.16 error
        logic load_prod;  // register step size times error
    } err_ctrl_t;

endpackage

`default_nettype wire

/* src/lsi_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module lsi_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lsi_pkg::cell_ctrl_t                  ctrl,
    input  logic signed [lsi_pkg::SAMPLE_W-1:0]  x_in,
    input  logic signed [lsi_pkg::COEF_W-1:0]    coef,
    input  logic signed [lsi_pkg::ACC_W-1:0]     acc_in,
    input  logic signed [lsi_pkg::P_W-1:0]       p,
    output logic signed [lsi_pkg::SAMPLE_W-1:0]  x_out,
    output logic signed [lsi_pkg::ACC_W-1:0]     acc_out
);
    import lsi_pkg::*;

    localparam logic signed [WGT_W-1:0] WGT_MAX = {1'b0, {(WGT_W-1){1'b1}}};
    localparam logic signed [WGT_W-1:0] WGT_MIN = {1'b1, {(WGT_W-1){1'b0}}};

    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [WGT_W-1:0]    w_reg, w_next;
    logic signed [DPROD_W-1:0]  dprod_reg;
    logic signed [YPROD_W-1:0]  yprod_reg;
    logic signed [ACC_W-1:0]    term_reg, term_next;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [UPD_W-1:0]    upd_reg;
    logic signed [P_W-1:0]      delta;
    logic signed [WGT_W:0]      wsum;

    assign term_next = (ACC_W'(dprod_reg) <<< PLANT_SHIFT) - ACC_W'(yprod_reg);

    // floor(p * x / 2^16), then saturate the weight
    assign delta = $signed(upd_reg[UPD_SHIFT +: P_W]);
    assign wsum  = (WGT_W+1)'(w_reg) + (WGT_W+1)'(delta);

    always_comb
    begin
        if (wsum[WGT_W] != wsum[WGT_W-1])
        begin
            w_next = wsum[WGT_W] ? WGT_MIN : WGT_MAX;
        end
        else
        begin
            w_next = wsum[WGT_W-1:0];
        end
    end

    // architectural state: tap sample and weight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            w_reg <= '0;
        end
        else
        begin
            if (ctrl.shift)
            begin
                x_reg <= x_in;
            end
            if (ctrl.upd)
            begin
                w_reg <= w_next;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (ctrl.mul)
        begin
            dprod_reg <= coef * x_reg;
            yprod_reg <= w_reg * x_reg;
        end
        if (ctrl.term)
        begin
            term_reg <= term_next;
        end
        if (ctrl.acc)
        begin
            acc_reg <= acc_in + term_reg;
        end
        if (ctrl.umul)
        begin
            upd_reg <= p * x_reg;
        end
    end

    assign x_out   = x_reg;
    assign acc_out = acc_reg;

endmodule

`default_nettype wire

/* src/lsi_err.sv */
`timescale 1ns / 1ps
`default_nettype none

module lsi_err (
    input  logic                                 clk,
    input  lsi_pkg::err_ctrl_t                   ctrl,
    input  logic signed [lsi_pkg::ACC_W-1:0]     err_sum,
    input  logic        [lsi_pkg::STEP_W-1:0]    step_size,
    output logic signed [lsi_pkg::SAMPLE_W-1:0]  err_q,
    output logic signed [lsi_pkg::P_W-1:0]       p
);
    import lsi_pkg::*;

    localparam int INT_W = ACC_W - OUT_SHIFT;
    localparam int EQF_W = ACC_W - EQ_SHIFT;
    localparam logic signed [INT_W-1:0] OUT_MAX = INT_W'(32767);
    localparam logic signed [INT_W-1:0] OUT_MIN = -INT_W'(32768);
    localparam logic signed [EQF_W-1:0] EQ_MAX  = {{(EQF_W-EQ_W+1){1'b0}}, {(EQ_W-1){1'b1}}};
    localparam logic signed [EQF_W-1:0] EQ_MIN  = {{(EQF_W-EQ_W+1){1'b1}}, {(EQ_W-1){1'b0}}};
    localparam logic [ACC_W-1:0] TRUNC_BIAS = {{(INT_W){1'b0}}, {(OUT_SHIFT){1'b1}}};

    logic signed [ACC_W-1:0]    biased;
    logic signed [INT_W-1:0]    whole;
    logic signed [EQF_W-1:0]    eq_full;
    logic signed [SAMPLE_W-1:0] err_next;
    logic signed [EQ_W-1:0]     eq_next;
    logic signed [EQ_W-1:0]     eq_reg;
    logic signed [SAMPLE_W-1:0] err_reg;
    logic signed [PPROD_W-1:0]  prod_reg;

    // truncate toward zero: bias negative values before the shift
    assign biased  = err_sum + (err_sum[ACC_W-1] ? $signed(TRUNC_BIAS) : '0);
    assign whole   = biased[ACC_W-1:OUT_SHIFT];
    assign eq_full = err_sum[ACC_W-1:EQ_SHIFT];

    always_comb
    begin
        priority if (whole > OUT_MAX)
        begin
            err_next = OUT_MAX[SAMPLE_W-1:0];
        end
        else if (whole < OUT_MIN)
        begin
            err_next = OUT_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            err_next = whole[SAMPLE_W-1:0];
        end

        priority if (eq_full > EQ_MAX)
        begin
            eq_next = EQ_MAX[EQ_W-1:0];
        end
        else if (eq_full < EQ_MIN)
        begin
            eq_next = EQ_MIN[EQ_W-1:0];
        end
        else
        begin
            eq_next = eq_full[EQ_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_err)
        begin
            err_reg <= err_next;
            eq_reg  <= eq_next;
        end
        if (ctrl.load_prod)
        begin
            prod_reg <= $signed({1'b0, step_size}) * eq_reg;
        end
    end

    assign err_q = err_reg;
    // floor(step * eq / 2^24) always fits in 32 bits
    assign p     = prod_reg[STEP_SHIFT +: P_W];

endmodule

`default_nettype wire

/* src/lms_system_identifier_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// error_out is offered once a sample has passed MUL, TERM, ACC, ERR and EMIT; in ACC
// the error sum ripples through the cells one tap per cycle. A new sample is taken
// only after UMUL and UPD return to IDLE; EMIT stalls while the last error is unread.
// A finished error waits in the output register while the next sample starts.
// Reset (rst_n low, asynchronous): delay line and weights clear to zero,
// plant coefficients return to 8192 and the step size to 72058.
module lms_system_identifier_unit #(
    parameter int TAPS = 4
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // sample channel
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [lsi_pkg::SAMPLE_W-1:0]    sample_in,
    // error channel
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [lsi_pkg::SAMPLE_W-1:0]    error_out,
    // configuration write port
    input  logic                                   cfg_we,
    input  logic        [lsi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic        [lsi_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lsi_pkg::*;

    localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TAPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_TERM,
        ST_ACC,
        ST_ERR,
        ST_EMIT,
        ST_UMUL,
        ST_UPD
    } state_t;

    state_t                     state_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] error_out_reg;

    logic signed [COEF_W-1:0]   coef_reg [NUM_COEF];
    logic        [STEP_W-1:0]   step_reg;

    cell_ctrl_t                 cell_ctrl;
    err_ctrl_t                  err_ctrl;
    logic                       in_xfer;
    logic                       out_free;

    logic signed [SAMPLE_W-1:0] cell_x_in   [TAPS];
    logic signed [COEF_W-1:0]   cell_coef   [TAPS];
    logic signed [ACC_W-1:0]    cell_acc_in [TAPS];
    logic signed [SAMPLE_W-1:0] x_link      [TAPS];
    logic signed [ACC_W-1:0]    acc_link    [TAPS];

    logic signed [SAMPLE_W-1:0] err_q;
    logic signed [P_W-1:0]      p;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    // the output slot can take a new error if empty or being drained now
    assign out_free = !out_valid_reg || out_ready;

    // Configuration registers: plant coefficients and step size.
    // Indexes past the step size are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                coef_reg[i] <= COEF_RESET;
            end
            step_reg <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index < CFG_IDX_W'(NUM_COEF))
            begin
                coef_reg[cfg_index[COEF_IDX_W-1:0]] <= $signed(cfg_data[COEF_W-1:0]);
            end
            else if (cfg_index == REG_STEP_SIZE)
            begin
                step_reg <= cfg_data[STEP_W-1:0];
            end
        end
    end

    // Sequencer: one sample at a time through the row of cells.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            error_out_reg <= '0;
        end
        else
        begin
            // drop valid once the error is taken, unless a new one replaces it
            if (out_valid_reg && out_ready && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_TERM;
                end
                ST_TERM:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    // hold until the sum has reached the last cell
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_reg <= ST_ERR;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_ERR:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    // hold until the previous error has been taken
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        error_out_reg <= err_q;
                        state_reg     <= ST_UMUL;
                    end
                    else
                    begin
                        out_valid_reg <= out_valid_reg;
                    end
                end
                ST_UMUL:
                begin
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        cell_ctrl.shift   = in_xfer;
        cell_ctrl.mul     = (state_reg == ST_MUL);
        cell_ctrl.term    = (state_reg == ST_TERM);
        cell_ctrl.acc     = (state_reg == ST_ACC);
        cell_ctrl.umul    = (state_reg == ST_UMUL);
        cell_ctrl.upd     = (state_reg == ST_UPD);
        err_ctrl.load_err  = (state_reg == ST_ERR);
        err_ctrl.load_prod = (state_reg == ST_EMIT);
    end

    // Row of tap cells: samples advance toward higher taps, the error sum
    // ripples the same way and leaves the last cell.
    for (genvar k = 0; k < TAPS; k++)
    begin : g_tap
        if (k == 0)
        begin : g_head
            assign cell_x_in[k]   = sample_in;
            assign cell_acc_in[k] = '0;
        end
        else
        begin : g_link
            assign cell_x_in[k]   = x_link[k-1];
            assign cell_acc_in[k] = acc_link[k-1];
        end

        // taps past the coefficient registers have no plant contribution
        if (k < NUM_COEF)
        begin : g_coef
            assign cell_coef[k] = coef_reg[k];
        end
        else
        begin : g_nocoef
            assign cell_coef[k] = '0;
        end

        lsi_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (cell_ctrl),
            .x_in    (cell_x_in[k]),
            .coef    (cell_coef[k]),
            .acc_in  (cell_acc_in[k]),
            .p       (p),
            .x_out   (x_link[k]),
            .acc_out (acc_link[k])
        );
    end

    lsi_err u_err (
        .clk       (clk),
        .ctrl      (err_ctrl),
        .err_sum   (acc_link[TAPS-1]),
        .step_size (step_reg),
        .err_q     (err_q),
        .p         (p)
    );

    assign out_valid = out_valid_reg;
    assign error_out = error_out_reg;

endmodule

`default_nettype wire
